// File: sv/uavw_pkg.sv
// Shared types, constants and the column-width lookup for the visible-width counter.
// No dependencies; imported by uavw_step, utf8_ansi_visible_width and the testbench.
`default_nettype none

package uavw_pkg;

   localparam int CODE_BITS  = 21;
   localparam int DELTA_BITS = 3;

   localparam logic [7:0] CHAR_BEL  = 8'h07;
   localparam logic [7:0] CHAR_ESC  = 8'h1B;
   localparam logic [7:0] CHAR_LBRK = 8'h5B;
   localparam logic [7:0] CHAR_RBRK = 8'h5D;
   localparam logic [7:0] CHAR_BSL  = 8'h5C;

   localparam logic [CODE_BITS-1:0] REPLACEMENT = 21'h00FFFD;

   typedef enum logic [2:0] {
      MODE_NORMAL  = 3'd0,
      MODE_UTF8    = 3'd1,
      MODE_ESC     = 3'd2,
      MODE_CSI     = 3'd3,
      MODE_OSC     = 3'd4,
      MODE_OSC_ESC = 3'd5
   } scan_mode_type;

   typedef struct packed {
      scan_mode_type        mode;
      logic [1:0]           expected;
      logic [1:0]           held;
      logic [CODE_BITS-1:0] accum;
   } scan_state_type;

   localparam scan_state_type SCAN_RESET = '{
      mode: MODE_NORMAL, expected: 2'd0, held: 2'd0, accum: '0};

   function automatic logic in_rng(input logic [CODE_BITS-1:0] cp,
                                   input logic [CODE_BITS-1:0] lo,
                                   input logic [CODE_BITS-1:0] hi);
      return (cp >= lo) && (cp <= hi);
   endfunction

   // Terminal columns of one code point: 0, 1 or 2.
   function automatic logic [1:0] cell_width(input logic [CODE_BITS-1:0] cp);
      logic zero_w;
      logic wide_w;
      zero_w = (cp < 21'h20) || in_rng(cp, 21'h7F, 21'h9F) ||
               in_rng(cp, 21'h0300, 21'h036F) || in_rng(cp, 21'h200B, 21'h200F) ||
               in_rng(cp, 21'hFE00, 21'hFE0F) || in_rng(cp, 21'h20D0, 21'h20F0) ||
               (cp == 21'hFEFF);
      wide_w = in_rng(cp, 21'h1100, 21'h115F) || in_rng(cp, 21'h2E80, 21'h303E) ||
               in_rng(cp, 21'h3041, 21'h33FF) || in_rng(cp, 21'h3400, 21'h4DBF) ||
               in_rng(cp, 21'h4E00, 21'h9FFF) || in_rng(cp, 21'hA000, 21'hA4CF) ||
               in_rng(cp, 21'hAC00, 21'hD7A3) || in_rng(cp, 21'hF900, 21'hFAFF) ||
               in_rng(cp, 21'hFE30, 21'hFE6F) || in_rng(cp, 21'hFF00, 21'hFF60) ||
               in_rng(cp, 21'hFFE0, 21'hFFE6) || in_rng(cp, 21'h1F300, 21'h1F64F) ||
               in_rng(cp, 21'h1F900, 21'h1F9FF) || in_rng(cp, 21'h20000, 21'h3FFFD);
      if (zero_w) begin
         return 2'd0;
      end else if (wide_w) begin
         return 2'd2;
      end
      return 2'd1;
   endfunction

   // Parameter bytes that keep a CSI open: digits ; : < = > ? and space.
   function automatic logic csi_param(input logic [7:0] b);
      return ((b >= 8'h30) && (b <= 8'h39)) || (b == 8'h3B) || (b == 8'h3A) ||
             (b == 8'h3C) || (b == 8'h3E) || (b == 8'h3D) || (b == 8'h20) ||
             (b == 8'h3F);
   endfunction

endpackage

`default_nettype wire

// File: sv/uavw_step.sv
// Per-byte scanner: next escape/UTF-8 state and columns added by one byte.
// Depends on uavw_pkg.
`default_nettype none

module uavw_step (
   input  uavw_pkg::scan_state_type      cur_state,
   input  logic [7:0]                    text_byte,
   input  logic                          end_of_text,
   output uavw_pkg::scan_state_type      nxt_state,
   output logic [uavw_pkg::DELTA_BITS-1:0] delta
);
   import uavw_pkg::*;

   localparam logic [1:0] REPL_W = cell_width(REPLACEMENT);

   scan_state_type st;
   logic           run_normal;
   logic           is_cont;
   logic [CODE_BITS-1:0] acc_next;
   logic [DELTA_BITS-1:0] d_flush;
   logic [DELTA_BITS-1:0] d_byte;
   logic [DELTA_BITS-1:0] d_end;

   assign is_cont  = (text_byte[7:6] == 2'b10);
   assign acc_next = {cur_state.accum[CODE_BITS-7:0], text_byte[5:0]};

   always_comb begin
      st         = cur_state;
      run_normal = 1'b0;
      d_flush    = '0;
      d_byte     = '0;
      d_end      = '0;

      case (cur_state.mode)
         MODE_UTF8: begin
            if (is_cont && (cur_state.expected != 2'd0)) begin
               st.accum    = acc_next;
               st.held     = cur_state.held + 2'd1;
               st.expected = cur_state.expected - 2'd1;
               if (cur_state.expected == 2'd1) begin
                  d_byte = {1'b0, cell_width(acc_next)};
                  st     = SCAN_RESET;
               end
            end else begin
               // broken sequence: one replacement per held byte, then rescan
               d_flush    = {1'b0, cur_state.held} * {1'b0, REPL_W};
               st         = SCAN_RESET;
               run_normal = 1'b1;
            end
         end
         MODE_ESC: begin
            if (text_byte == CHAR_LBRK) begin
               st.mode = MODE_CSI;
            end else if (text_byte == CHAR_RBRK) begin
               st.mode = MODE_OSC;
            end else begin
               st.mode = MODE_NORMAL;
            end
         end
         MODE_CSI: begin
            if (!csi_param(text_byte)) begin
               st.mode = MODE_NORMAL;
            end
         end
         MODE_OSC, MODE_OSC_ESC: begin
            if ((cur_state.mode == MODE_OSC_ESC) && (text_byte == CHAR_BSL)) begin
               st.mode = MODE_NORMAL;
            end else if (text_byte == CHAR_BEL) begin
               st.mode = MODE_NORMAL;
            end else if (text_byte == CHAR_ESC) begin
               st.mode = MODE_OSC_ESC;
            end else begin
               st.mode = MODE_OSC;
            end
         end
         default: begin
            st.mode    = MODE_NORMAL;
            run_normal = 1'b1;
         end
      endcase

      if (run_normal) begin
         if (text_byte == CHAR_ESC) begin
            st.mode = MODE_ESC;
         end else if (!text_byte[7]) begin
            d_byte = {1'b0, cell_width({{(CODE_BITS-8){1'b0}}, text_byte})};
         end else if (text_byte[7:5] == 3'b110) begin
            st = '{mode: MODE_UTF8, expected: 2'd1, held: 2'd1,
                   accum: {{(CODE_BITS-5){1'b0}}, text_byte[4:0]}};
         end else if (text_byte[7:4] == 4'b1110) begin
            st = '{mode: MODE_UTF8, expected: 2'd2, held: 2'd1,
                   accum: {{(CODE_BITS-4){1'b0}}, text_byte[3:0]}};
         end else if (text_byte[7:3] == 5'b11110) begin
            st = '{mode: MODE_UTF8, expected: 2'd3, held: 2'd1,
                   accum: {{(CODE_BITS-3){1'b0}}, text_byte[2:0]}};
         end else begin
            d_byte = {1'b0, REPL_W};
         end
      end

      // last byte: flush an open sequence, and the string starts over
      if (end_of_text) begin
         if (st.mode == MODE_UTF8) begin
            d_end = {1'b0, st.held} * {1'b0, REPL_W};
         end
         st = SCAN_RESET;
      end
   end

   assign nxt_state = st;
   assign delta     = d_flush + d_byte + d_end;

endmodule

`default_nettype wire

// File: sv/utf8_ansi_visible_width.sv
// Top level of the visible-width counter: input register, scanner, saturating
// column sum and result register. Depends on uavw_pkg and uavw_step.
//
// Usage:
//   req_ channel: one string byte per beat (req_text_byte), with
//   req_end_of_text set on the last byte of the string.
//   rsp_ channel: one beat per input byte, carrying the running column count
//   of the string up to and including that byte (rsp_column_total,
//   saturating at 2^WIDTH_BITS - 1) and rsp_string_done on the last one.
//   ANSI escapes (CSI, OSC, two-byte) add no columns; UTF-8 is decoded and
//   each code point adds 0, 1 or 2 columns.
// Timing:
//   A byte accepted into the input register goes through the scanner and is
//   loaded into the result register once the result stage is free or draining.
//   Throughput is one byte per cycle while rsp_ready stays high; the scanner
//   state (mode, pending UTF-8 bytes, column sum) updates with the result register.
// Reset: synchronous, clears both stages and returns to plain text with a
//   zero count. After a last byte the scanner also returns to that state.
// Stall: while rsp_ready is low the result holds; the input register still
//   takes one more byte, then req_ready drops until the result drains.
`default_nettype none

module utf8_ansi_visible_width #(
   parameter int WIDTH_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_text_byte,
   input  logic                  req_end_of_text,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [WIDTH_BITS-1:0] rsp_column_total,
   output logic                  rsp_string_done
);
   import uavw_pkg::*;

   // input stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // scanner state and running sum
   scan_state_type        state_ff, state_in;
   logic [WIDTH_BITS-1:0] sum_ff, sum_in;

   // result stage
   logic                  out_valid_ff, out_valid_in;
   logic [WIDTH_BITS-1:0] total_ff;
   logic                  done_ff;

   logic                  advance;
   logic                  req_fire;
   logic [DELTA_BITS-1:0] delta;
   logic [WIDTH_BITS:0]   sum_wide;
   logic [WIDTH_BITS-1:0] sum_sat;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   uavw_step u_step (
      .cur_state   (state_ff),
      .text_byte   (in_byte_ff),
      .end_of_text (in_last_ff),
      .nxt_state   (state_in),
      .delta       (delta)
   );

   // saturating add; at most four columns per byte
   assign sum_wide = {1'b0, sum_ff} + {{(WIDTH_BITS-DELTA_BITS+1){1'b0}}, delta};
   assign sum_sat  = sum_wide[WIDTH_BITS] ? {WIDTH_BITS{1'b1}} : sum_wide[WIDTH_BITS-1:0];
   assign sum_in   = in_last_ff ? '0 : sum_sat;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= SCAN_RESET;
         sum_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
            sum_ff   <= sum_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_text_byte;
         in_last_ff <= req_end_of_text;
      end
      if (advance) begin
         total_ff <= sum_sat;
         done_ff  <= in_last_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_column_total = total_ff;
   assign rsp_string_done  = done_ff;

`ifndef ASSERT_OFF
   // a closed string leaves the scanner in plain text with a zero count
   a_string_restart: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> (sum_ff == '0) && (state_ff.mode == MODE_NORMAL))
      else $error("scanner not cleared after last byte");

   // within a string the count never goes down
   a_sum_monotonic: assert property (@(posedge clock) disable iff (reset)
      advance && !in_last_ff |=> sum_ff >= $past(sum_ff))
      else $error("column sum decreased");

   // outside a UTF-8 sequence nothing is held
   a_seq_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode != MODE_UTF8 |-> (state_ff.held == 2'd0) &&
                                     (state_ff.expected == 2'd0))
      else $error("sequence bytes held outside UTF-8 mode");

   // an open sequence always waits for at least one continuation byte
   a_seq_open: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode == MODE_UTF8 |-> (state_ff.expected != 2'd0) &&
                                     (state_ff.held != 2'd0))
      else $error("open UTF-8 sequence with nothing pending");

   // a processed byte always lands in the result register
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff && (total_ff == $past(sum_sat)))
      else $error("result register not loaded");
`endif

endmodule

`default_nettype wire

// File: verif/tb_utf8_ansi_visible_width.sv
// Self-checking testbench for utf8_ansi_visible_width: directed byte table and random
// strings, checked against a behavioral column counter or typed-in totals.
// Depends on uavw_pkg and the utf8_ansi_visible_width RTL.
`default_nettype none

module tb_utf8_ansi_visible_width;
   import uavw_pkg::*;

   localparam int SUM_BITS     = 16;
   localparam int SUM_MAX      = (1 << SUM_BITS) - 1;
   localparam int IDLE_LIMIT   = 2000;  // cycles without any beat before giving up
   localparam int RANDOM_BYTES = 1600;
   localparam int DRAIN_CYCLES = 8;     // slack after the last expected result
   localparam int NUM_SPANS    = 21;
   localparam int FIRST_WIDE   = 7;     // spans below this index are zero width

   // ------------------------------------------------------------------
   // Clock, reset and DUT
   // ------------------------------------------------------------------
   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_ready;
   logic [7:0]          req_text_byte   = 8'h00;
   logic                req_end_of_text = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready       = 1'b0;
   logic [SUM_BITS-1:0] rsp_column_total;
   logic                rsp_string_done;

   always #1 clock = ~clock;

   utf8_ansi_visible_width #(
      .WIDTH_BITS(SUM_BITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_column_total (rsp_column_total),
      .rsp_string_done  (rsp_string_done)
   );

   // ------------------------------------------------------------------
   // Expected results, one per accepted input beat, oldest first
   // ------------------------------------------------------------------
   typedef struct packed {
      logic [SUM_BITS-1:0] total;
      logic                done;
   } col_result_type;

   col_result_type pending_totals [$];
   int             mismatches = 0;

   // ------------------------------------------------------------------
   // Column counter: code point ranges, then the byte scanner
   // ------------------------------------------------------------------

   // {lo, hi} of each width range; zero-width ranges come first.
   function automatic logic [41:0] span_of(input int k);
      case (k)
         0:       return {21'h00000, 21'h0001F};
         1:       return {21'h0007F, 21'h0009F};
         2:       return {21'h00300, 21'h0036F};
         3:       return {21'h0200B, 21'h0200F};
         4:       return {21'h0FE00, 21'h0FE0F};
         5:       return {21'h020D0, 21'h020F0};
         6:       return {21'h0FEFF, 21'h0FEFF};
         7:       return {21'h01100, 21'h0115F};
         8:       return {21'h02E80, 21'h0303E};
         9:       return {21'h03041, 21'h033FF};
         10:      return {21'h03400, 21'h04DBF};
         11:      return {21'h04E00, 21'h09FFF};
         12:      return {21'h0A000, 21'h0A4CF};
         13:      return {21'h0AC00, 21'h0D7A3};
         14:      return {21'h0F900, 21'h0FAFF};
         15:      return {21'h0FE30, 21'h0FE6F};
         16:      return {21'h0FF00, 21'h0FF60};
         17:      return {21'h0FFE0, 21'h0FFE6};
         18:      return {21'h1F300, 21'h1F64F};
         19:      return {21'h1F900, 21'h1F9FF};
         default: return {21'h20000, 21'h3FFFD};
      endcase
   endfunction

   function automatic int col_of(input logic [20:0] cp);
      logic [41:0] s;
      for (int k = 0; k < NUM_SPANS; k++) begin
         s = span_of(k);
         if (cp >= s[41:21] && cp <= s[20:0]) begin
            return (k < FIRST_WIDE) ? 0 : 2;
         end
      end
      return 1;
   endfunction

   // Bytes that keep a CSI open; anything else is its final byte.
   function automatic logic csi_keeps(input logic [7:0] b);
      return (b >= "0" && b <= "9") || b == ";" || b == ":" || b == "<" ||
             b == ">" || b == "=" || b == "?" || b == " ";
   endfunction

   scan_mode_type trk_mode = MODE_NORMAL;
   logic [1:0]    trk_need = '0;   // continuation bytes still owed
   logic [1:0]    trk_held = '0;   // bytes of the open sequence so far
   logic [20:0]   trk_code = '0;
   int            trk_cols = 0;

   task automatic add_cols(input int w);
      trk_cols = (trk_cols + w > SUM_MAX) ? SUM_MAX : trk_cols + w;
   endtask

   task automatic drop_seq();
      trk_need = '0;
      trk_held = '0;
      trk_code = '0;
   endtask

   // Broken or cut-off sequence: every held byte shows as one replacement char.
   task automatic flush_seq();
      add_cols(int'(trk_held) * col_of(REPLACEMENT));
      drop_seq();
      trk_mode = MODE_NORMAL;
   endtask

   task automatic open_seq(input logic [20:0] bits, input logic [1:0] need);
      trk_code = bits;
      trk_need = need;
      trk_held = 2'd1;
      trk_mode = MODE_UTF8;
   endtask

   task automatic plain_byte(input logic [7:0] b);
      if (b == CHAR_ESC) begin
         trk_mode = MODE_ESC;
      end else if (!b[7]) begin
         add_cols(col_of({13'd0, b}));
      end else if (b[7:5] == 3'b110) begin
         open_seq({16'd0, b[4:0]}, 2'd1);
      end else if (b[7:4] == 4'b1110) begin
         open_seq({17'd0, b[3:0]}, 2'd2);
      end else if (b[7:3] == 5'b11110) begin
         open_seq({18'd0, b[2:0]}, 2'd3);
      end else begin
         // stray continuation or a lead of five bytes or more
         add_cols(col_of(REPLACEMENT));
      end
   endtask

   task automatic osc_byte(input logic [7:0] b);
      if (b == CHAR_BEL) begin
         trk_mode = MODE_NORMAL;
      end else if (b == CHAR_ESC) begin
         trk_mode = MODE_OSC_ESC;
      end else begin
         trk_mode = MODE_OSC;
      end
   endtask

   // Advance the counter by one byte and return the running total of the string.
   task automatic track_byte(input logic [7:0] b, input logic last,
                             output logic [SUM_BITS-1:0] total);
      case (trk_mode)
         MODE_UTF8: begin
            if (b[7:6] == 2'b10 && trk_need != 2'd0) begin
               trk_code = {trk_code[14:0], b[5:0]};
               trk_held = trk_held + 2'd1;
               trk_need = trk_need - 2'd1;
               if (trk_need == 2'd0) begin
                  add_cols(col_of(trk_code));
                  drop_seq();
                  trk_mode = MODE_NORMAL;
               end
            end else begin
               flush_seq();
               plain_byte(b);
            end
         end
         MODE_ESC: begin
            // anything but [ or ] is swallowed as a two-byte escape
            if (b == CHAR_LBRK) begin
               trk_mode = MODE_CSI;
            end else if (b == CHAR_RBRK) begin
               trk_mode = MODE_OSC;
            end else begin
               trk_mode = MODE_NORMAL;
            end
         end
         MODE_CSI: begin
            if (!csi_keeps(b)) begin
               trk_mode = MODE_NORMAL;
            end
         end
         MODE_OSC: begin
            osc_byte(b);
         end
         MODE_OSC_ESC: begin
            // ESC not followed by backslash is dropped, byte stays in the OSC
            if (b == CHAR_BSL) begin
               trk_mode = MODE_NORMAL;
            end else begin
               osc_byte(b);
            end
         end
         default: begin
            trk_mode = MODE_NORMAL;
            plain_byte(b);
         end
      endcase
      if (last && trk_mode == MODE_UTF8) begin
         flush_seq();
      end
      total = trk_cols[SUM_BITS-1:0];
      if (last) begin
         // open escapes are simply dropped; next byte starts a fresh string
         trk_mode = MODE_NORMAL;
         drop_seq();
         trk_cols = 0;
      end
   endtask

   // ------------------------------------------------------------------
   // Sender: bursts of beats with random gaps in between
   // ------------------------------------------------------------------
   int burst_left = 0;

   // Offer one byte, hold it until accepted, then record what should come back.
   // known/want override the counter for rows whose total is typed in.
   task automatic send_byte(input logic [7:0] b, input logic last,
                            input logic known, input logic [SUM_BITS-1:0] want);
      int                  gap;
      logic [SUM_BITS-1:0] total;
      col_result_type      exp_item;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      req_valid       <= 1'b1;
      req_text_byte   <= b;
      req_end_of_text <= last;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      track_byte(b, last, total);
      exp_item.total = known ? want : total;
      exp_item.done  = last;
      pending_totals.insert(pending_totals.size(), exp_item);
   endtask

   // ------------------------------------------------------------------
   // Random text: strings built from well-formed pieces plus some noise
   // ------------------------------------------------------------------
   logic [7:0] text_q [$];

   task automatic put_text(input logic [7:0] b);
      text_q.insert(text_q.size(), b);
   endtask

   // Mostly range edges of the width table, sometimes any 21-bit value.
   function automatic logic [20:0] pick_code();
      logic [41:0] s;
      if ($urandom_range(0, 4) == 0) begin
         return 21'($urandom_range(0, 21'h1FFFFF));
      end
      s = span_of($urandom_range(0, NUM_SPANS - 1));
      case ($urandom_range(0, 4))
         0:       return s[41:21] - 21'd1;
         1:       return s[41:21];
         2:       return s[20:0];
         3:       return s[20:0] + 21'd1;
         default: return 21'($urandom_range(s[41:21], s[20:0]));
      endcase
   endfunction

   // UTF-8 encode; now and then one byte longer than needed (overlong form).
   task automatic push_code(input logic [20:0] cp);
      int nb;
      nb = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
      if (nb < 4 && $urandom_range(0, 9) == 0) begin
         nb++;
      end
      case (nb)
         1: put_text(cp[7:0]);
         2: begin
            put_text({3'b110, cp[10:6]});
            put_text({2'b10, cp[5:0]});
         end
         3: begin
            put_text({4'b1110, cp[15:12]});
            put_text({2'b10, cp[11:6]});
            put_text({2'b10, cp[5:0]});
         end
         default: begin
            put_text({5'b11110, cp[20:18]});
            put_text({2'b10, cp[17:12]});
            put_text({2'b10, cp[11:6]});
            put_text({2'b10, cp[5:0]});
         end
      endcase
   endtask

   function automatic logic [7:0] csi_param_byte();
      case ($urandom_range(0, 7))
         0:       return ";";
         1:       return ":";
         2:       return "<";
         3:       return ">";
         4:       return "=";
         5:       return "?";
         6:       return " ";
         default: return 8'("0" + $urandom_range(0, 9));
      endcase
   endfunction

   task automatic emit_piece();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 28) begin
         put_text(8'($urandom_range(8'h20, 8'h7E)));
      end else if (r < 33) begin
         put_text($urandom_range(0, 1) ? 8'h7F : 8'($urandom_range(0, 8'h1F)));
      end else if (r < 60) begin
         push_code(pick_code());
      end else if (r < 67) begin
         // CSI: params then a final byte, sometimes an odd one
         put_text(CHAR_ESC);
         put_text(CHAR_LBRK);
         n = $urandom_range(0, 4);
         repeat (n) put_text(csi_param_byte());
         put_text(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(8'h40, 8'h7E)));
      end else if (r < 74) begin
         // OSC with printable payload, maybe a lone ESC inside
         put_text(CHAR_ESC);
         put_text(CHAR_RBRK);
         n = $urandom_range(0, 6);
         repeat (n) put_text(8'($urandom_range(8'h20, 8'h7E)));
         if ($urandom_range(0, 3) == 0) begin
            put_text(CHAR_ESC);
            put_text(8'($urandom_range(8'h20, 8'h5B)));
         end
         if ($urandom_range(0, 1)) begin
            put_text(CHAR_BEL);
         end else begin
            put_text(CHAR_ESC);
            put_text(CHAR_BSL);
         end
      end else if (r < 78) begin
         put_text(CHAR_ESC);
         put_text(8'($urandom_range(0, 255)));
      end else if (r < 88) begin
         // lead byte with too few continuations
         n = $urandom_range(1, 3);
         case (n)
            1:       put_text({3'b110, 5'($urandom_range(0, 31))});
            2:       put_text({4'b1110, 4'($urandom_range(0, 15))});
            default: put_text({5'b11110, 3'($urandom_range(0, 7))});
         endcase
         repeat ($urandom_range(0, n - 1)) put_text(8'($urandom_range(8'h80, 8'hBF)));
      end else begin
         put_text(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic send_text();
      foreach (text_q[i]) begin
         send_byte(text_q[i], i == text_q.size() - 1, 1'b0, '0);
      end
      text_q.delete();
   endtask

   // ------------------------------------------------------------------
   // Directed rows: totals typed in where obvious, else from the counter
   // ------------------------------------------------------------------
   typedef struct packed {
      logic [7:0]          text;
      logic                last;
      logic                known;
      logic [SUM_BITS-1:0] total;
   } dir_row_type;

   dir_row_type dir_rows [25] = '{
      '{8'h00, 1'b0, 1'b1, 16'd0},   // NUL right after reset: zero width
      '{8'h41, 1'b0, 1'b1, 16'd1},
      '{8'hFF, 1'b0, 1'b1, 16'd2},   // invalid lead
      '{8'h80, 1'b0, 1'b1, 16'd3},   // stray continuation
      '{8'hE4, 1'b0, 1'b0, 16'd0},   // U+4E00, wide
      '{8'hB8, 1'b0, 1'b0, 16'd0},
      '{8'h80, 1'b0, 1'b0, 16'd0},
      '{8'hC3, 1'b0, 1'b0, 16'd0},   // lead broken by plain 'A'
      '{8'h41, 1'b0, 1'b0, 16'd0},
      '{8'h1B, 1'b0, 1'b0, 16'd0},   // CSI ESC [ 3 m
      '{8'h5B, 1'b0, 1'b0, 16'd0},
      '{8'h33, 1'b0, 1'b0, 16'd0},
      '{8'h6D, 1'b0, 1'b0, 16'd0},
      '{8'h1B, 1'b0, 1'b0, 16'd0},   // OSC with a lone ESC, ended by ESC backslash
      '{8'h5D, 1'b0, 1'b0, 16'd0},
      '{8'h1B, 1'b0, 1'b0, 16'd0},
      '{8'h41, 1'b0, 1'b0, 16'd0},
      '{8'h1B, 1'b0, 1'b0, 16'd0},
      '{8'h5C, 1'b0, 1'b0, 16'd0},
      '{8'h1B, 1'b0, 1'b0, 16'd0},   // two-byte escape eats a UTF-8 lead
      '{8'hF0, 1'b0, 1'b0, 16'd0},
      '{8'hF7, 1'b0, 1'b0, 16'd0},   // 4-byte lead cut off by end of text
      '{8'hBF, 1'b1, 1'b0, 16'd0},
      '{8'h1B, 1'b1, 1'b1, 16'd0},   // open escape at end: dropped
      '{8'h41, 1'b1, 1'b1, 16'd1}    // one-byte string, count restarted
   };

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      int random_sent;
      random_sent = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_byte(dir_rows[i].text, dir_rows[i].last, dir_rows[i].known, dir_rows[i].total);
      end

      while (random_sent < RANDOM_BYTES) begin
         repeat ($urandom_range(1, 12)) emit_piece();
         random_sent += text_q.size();
         send_text();
      end
      req_valid <= 1'b0;

      while (pending_totals.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Receiver: ready alternates between runs and stalls of random length,
   // with an occasional long run that never stalls
   // ------------------------------------------------------------------
   int ready_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         ready_left <= 0;
      end else if (ready_left == 0) begin
         rsp_ready <= ~rsp_ready;
         if (rsp_ready) begin
            ready_left <= $urandom_range(1, 6);
         end else begin
            ready_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(150, 400)
                                                      : $urandom_range(1, 20);
         end
      end else begin
         ready_left <= ready_left - 1;
      end
   end

   // ------------------------------------------------------------------
   // Result check: each response beat against the oldest expectation
   // ------------------------------------------------------------------
   int results_seen = 0;

   task automatic report(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s", msg);
      end
   endtask

   always @(posedge clock) begin
      col_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_totals.size() == 0) begin
            report($sformatf("result beat %0d with nothing expected: column_total %0d done %0b",
                             results_seen, rsp_column_total, rsp_string_done));
         end else begin
            want = pending_totals.pop_front();
            if (rsp_column_total !== want.total || rsp_string_done !== want.done) begin
               report($sformatf({"result beat %0d: column_total exp %0d got %0d, ",
                                 "string_done exp %0b got %0b"},
                                results_seen, want.total, rsp_column_total,
                                want.done, rsp_string_done));
            end
         end
         results_seen++;
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: too long without a beat on either channel ends the run
   // ------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

`default_nettype wire
